FILE: rtl/pidtw_pkg.sv
`timescale 1ns / 1ps
// Package for the PID controller with twiddle tuning: register map, reset values,
// configuration and gain-load structs. No dependencies.
package pidtw_pkg;

  localparam int unsigned APB_ADDR_WIDTH = 5;
  localparam int unsigned APB_DATA_WIDTH = 32;
  localparam int unsigned ACC_WIDTH      = 32;
  localparam int unsigned CNT_WIDTH      = 16;

  // Register indexes (byte address = 4 * index)
  typedef enum logic [2:0] {
    REG_GAIN_P       = 3'd0,
    REG_GAIN_I       = 3'd1,
    REG_GAIN_D       = 3'd2,
    REG_TUNE_ENABLE  = 3'd3,
    REG_TUNE_SELECT  = 3'd4,
    REG_WINDOW_START = 3'd5,
    REG_WINDOW_END   = 3'd6
  } reg_idx_e;

  // Tuned-gain select codes; the fourth code disables the twiddle step
  localparam logic [1:0] SEL_P = 2'd0;
  localparam logic [1:0] SEL_I = 2'd1;
  localparam logic [1:0] SEL_D = 2'd2;

  localparam logic [1:0]           TUNE_SELECT_RST  = SEL_D;
  localparam logic [CNT_WIDTH-1:0] WINDOW_START_RST = 16'd1000;
  localparam logic [CNT_WIDTH-1:0] WINDOW_END_RST   = 16'd2000;
  localparam logic [CNT_WIDTH-1:0] SAMPLE_COUNT_RST = 16'd1;

  typedef struct packed {
    logic                 tune_enable;
    logic [1:0]           tune_select;
    logic [CNT_WIDTH-1:0] window_start;
    logic [CNT_WIDTH-1:0] window_end;
  } tune_cfg_t;

  typedef struct packed {
    logic       load;
    logic [1:0] idx;
  } gain_load_t;

endpackage

FILE: rtl/pidtw_div10.sv
`timescale 1ns / 1ps
// Signed division by ten, rounded toward zero, by reciprocal multiplication.
// Depends on nothing.
module pidtw_div10 #(
  parameter int unsigned WIDTH = 24
) (
  input  logic signed [WIDTH-1:0] value_i,
  output logic signed [WIDTH-1:0] quotient_o
);

  // ceil(2^(WIDTH+3)/10) is exact for every magnitude below 2^WIDTH
  localparam int unsigned SHIFT = WIDTH + 3;
  localparam logic [WIDTH-1:0] RECIP = WIDTH'(((64'd1 << SHIFT) + 64'd9) / 64'd10);

  logic             neg;
  logic [WIDTH-1:0] mag;
  logic [2*WIDTH-1:0] prod;
  logic [WIDTH-1:0] quot_mag;

  assign neg      = value_i[WIDTH-1];
  assign mag      = neg ? (~value_i + 1'b1) : value_i;
  assign prod     = mag * RECIP;
  assign quot_mag = WIDTH'(prod >> SHIFT);
  assign quotient_o = neg ? $signed(~quot_mag + 1'b1) : $signed(quot_mag);

endmodule

FILE: rtl/pidtw_cfg.sv
`timescale 1ns / 1ps
// APB register file of the PID twiddle unit; produces the tuning config and gain loads.
// Depends on pidtw_pkg and pidtw_div10.
module pidtw_cfg #(
  parameter int unsigned GAIN_WIDTH = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [pidtw_pkg::APB_ADDR_WIDTH-1:0] paddr,
  input  logic [pidtw_pkg::APB_DATA_WIDTH-1:0] pwdata,
  output logic [pidtw_pkg::APB_DATA_WIDTH-1:0] prdata,
  output logic                                 pready,
  output pidtw_pkg::tune_cfg_t                 cfg_o,
  output pidtw_pkg::gain_load_t                load_o,
  output logic signed [GAIN_WIDTH-1:0]         load_gain_o,
  output logic signed [GAIN_WIDTH-1:0]         load_step_o
);
  import pidtw_pkg::*;

  logic signed [GAIN_WIDTH-1:0] gain_p_q, gain_i_q, gain_d_q;
  tune_cfg_t                    cfg_q;
  logic                         wr_en;
  reg_idx_e                     idx;
  logic signed [GAIN_WIDTH-1:0] wr_gain;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign idx     = reg_idx_e'(paddr[4:2]);
  assign wr_gain = $signed(pwdata[GAIN_WIDTH-1:0]);

  pidtw_div10 #(.WIDTH(GAIN_WIDTH)) u_div10 (
    .value_i    (wr_gain),
    .quotient_o (load_step_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q           <= '0;
      gain_i_q           <= '0;
      gain_d_q           <= '0;
      cfg_q.tune_enable  <= 1'b0;
      cfg_q.tune_select  <= TUNE_SELECT_RST;
      cfg_q.window_start <= WINDOW_START_RST;
      cfg_q.window_end   <= WINDOW_END_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_GAIN_P:       gain_p_q           <= wr_gain;
        REG_GAIN_I:       gain_i_q           <= wr_gain;
        REG_GAIN_D:       gain_d_q           <= wr_gain;
        REG_TUNE_ENABLE:  cfg_q.tune_enable  <= pwdata[0];
        REG_TUNE_SELECT:  cfg_q.tune_select  <= pwdata[1:0];
        REG_WINDOW_START: cfg_q.window_start <= pwdata[CNT_WIDTH-1:0];
        REG_WINDOW_END:   cfg_q.window_end   <= pwdata[CNT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_GAIN_P:       prdata = APB_DATA_WIDTH'(gain_p_q);
      REG_GAIN_I:       prdata = APB_DATA_WIDTH'(gain_i_q);
      REG_GAIN_D:       prdata = APB_DATA_WIDTH'(gain_d_q);
      REG_TUNE_ENABLE:  prdata = APB_DATA_WIDTH'(cfg_q.tune_enable);
      REG_TUNE_SELECT:  prdata = APB_DATA_WIDTH'(cfg_q.tune_select);
      REG_WINDOW_START: prdata = APB_DATA_WIDTH'(cfg_q.window_start);
      REG_WINDOW_END:   prdata = APB_DATA_WIDTH'(cfg_q.window_end);
      default:          prdata = '0;
    endcase
  end

  // A gain write also reloads the active gain and its step size
  assign load_o.load = wr_en &&
                       (idx == REG_GAIN_P || idx == REG_GAIN_I || idx == REG_GAIN_D);
  assign load_o.idx  = paddr[3:2];
  assign load_gain_o = wr_gain;
  assign cfg_o       = cfg_q;

endmodule

FILE: rtl/pidtw_tune.sv
`timescale 1ns / 1ps
// Controller state: integral, previous error, tuning window and twiddle gain update.
// Depends on pidtw_pkg and pidtw_div10.
module pidtw_tune #(
  parameter int unsigned GAIN_WIDTH   = 24,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  fire_i,
  input  logic signed [SAMPLE_WIDTH-1:0]        error_sample_i,
  input  pidtw_pkg::tune_cfg_t                  cfg_i,
  input  pidtw_pkg::gain_load_t                 load_i,
  input  logic signed [GAIN_WIDTH-1:0]          load_gain_i,
  input  logic signed [GAIN_WIDTH-1:0]          load_step_i,
  output logic signed [GAIN_WIDTH-1:0]          gains_o [3],
  output logic signed [pidtw_pkg::ACC_WIDTH-1:0] integral_o,
  output logic signed [SAMPLE_WIDTH:0]          diff_o,
  output logic                                  restart_o
);
  import pidtw_pkg::*;

  localparam int unsigned GW = GAIN_WIDTH;
  localparam int unsigned EW = GW + 2;
  localparam logic signed [EW-1:0] GMAX = $signed({3'b000, {(GW-1){1'b1}}});
  localparam logic signed [EW-1:0] GMIN = $signed({3'b111, {(GW-1){1'b0}}});
  localparam logic signed [EW-1:0] EONE = EW'(1);

  function automatic logic signed [GW-1:0] sat_gain(input logic signed [EW-1:0] v);
    logic signed [GW-1:0] r;
    if (v > GMAX)      r = GMAX[GW-1:0];
    else if (v < GMIN) r = GMIN[GW-1:0];
    else               r = v[GW-1:0];
    return r;
  endfunction

  logic signed [GW-1:0]           gains_q [3], gains_d [3];
  logic signed [GW-1:0]           steps_q [3], steps_d [3];
  logic signed [SAMPLE_WIDTH-1:0] prev_q, prev_d;
  logic signed [ACC_WIDTH-1:0]    integ_q, integ_d;
  logic [CNT_WIDTH-1:0]           cnt_q, cnt_d;
  logic [ACC_WIDTH-1:0]           wsum_q, wsum_d, best_q, best_d;
  logic                           best_valid_q, best_valid_d;
  logic                           inc_tried_q, inc_tried_d;
  logic                           dec_tried_q, dec_tried_d;

  logic [CNT_WIDTH-1:0]    cnt_inc;
  logic                    in_win, win_end, sel_ok;
  logic [SAMPLE_WIDTH-1:0] e_abs;
  logic [ACC_WIDTH:0]      wsum_add;
  logic [ACC_WIDTH-1:0]    wsum_sat, best_eff;
  logic signed [ACC_WIDTH:0] integ_add;
  logic signed [ACC_WIDTH-1:0] integ_sat;
  logic signed [GW-1:0]    g_sel, st_sel, st_tenth;
  logic signed [EW-1:0]    st_rem, st_adj;
  logic signed [GW-1:0]    step_up, step_dn, gain_inc, gain_up, gain_dn2;
  logic                    restart;

  // Window counter and absolute-error sum
  assign cnt_inc  = cnt_q + 1'b1;
  assign in_win   = (cnt_inc > cfg_i.window_start) && (cnt_inc < cfg_i.window_end);
  assign win_end  = cnt_inc >= cfg_i.window_end;
  assign e_abs    = error_sample_i[SAMPLE_WIDTH-1] ? (~error_sample_i + 1'b1)
                                                   : error_sample_i;
  assign wsum_add = (ACC_WIDTH+1)'(wsum_q) + (ACC_WIDTH+1)'(e_abs);
  assign wsum_sat = wsum_add[ACC_WIDTH] ? '1 : wsum_add[ACC_WIDTH-1:0];

  // Saturating integral
  assign integ_add = (ACC_WIDTH+1)'(integ_q) + (ACC_WIDTH+1)'(error_sample_i);
  always_comb begin
    if (integ_add[ACC_WIDTH] != integ_add[ACC_WIDTH-1]) begin
      integ_sat = integ_add[ACC_WIDTH] ? $signed({1'b1, {(ACC_WIDTH-1){1'b0}}})
                                       : $signed({1'b0, {(ACC_WIDTH-1){1'b1}}});
    end else begin
      integ_sat = integ_add[ACC_WIDTH-1:0];
    end
  end

  // Twiddle candidates for the selected gain
  assign sel_ok   = (cfg_i.tune_select == SEL_P) || (cfg_i.tune_select == SEL_I) ||
                    (cfg_i.tune_select == SEL_D);
  assign g_sel    = sel_ok ? gains_q[cfg_i.tune_select] : '0;
  assign st_sel   = sel_ok ? steps_q[cfg_i.tune_select] : '0;
  assign best_eff = best_valid_q ? best_q : wsum_q;

  pidtw_div10 #(.WIDTH(GW)) u_div10 (
    .value_i    (st_sel),
    .quotient_o (st_tenth)
  );

  // step*11/10 = step + step/10 under truncation. For step*9/10 the tenth is
  // rounded away from zero instead, so take one more off when step/10 is inexact.
  assign st_rem   = EW'(st_sel) - ((EW'(st_tenth) <<< 3) + (EW'(st_tenth) <<< 1));
  assign st_adj   = (st_rem == '0) ? '0 : (st_sel[GW-1] ? -EONE : EONE);
  assign step_up  = sat_gain(EW'(st_sel) + EW'(st_tenth));
  assign step_dn  = sat_gain(EW'(st_sel) - EW'(st_tenth) - st_adj);
  assign gain_inc = sat_gain(EW'(g_sel) + EW'(st_sel));
  assign gain_up  = sat_gain(EW'(g_sel) + EW'(step_up));
  assign gain_dn2 = sat_gain(EW'(g_sel) - (EW'(st_sel) <<< 1));

  always_comb begin
    gains_d      = gains_q;
    steps_d      = steps_q;
    prev_d       = prev_q;
    integ_d      = integ_q;
    cnt_d        = cnt_q;
    wsum_d       = wsum_q;
    best_d       = best_q;
    best_valid_d = best_valid_q;
    inc_tried_d  = inc_tried_q;
    dec_tried_d  = dec_tried_q;
    restart      = 1'b0;

    if (load_i.load) begin
      gains_d[load_i.idx] = load_gain_i;
      steps_d[load_i.idx] = load_step_i;
    end

    if (fire_i) begin
      prev_d  = error_sample_i;
      integ_d = integ_sat;
      if (cfg_i.tune_enable) begin
        cnt_d = cnt_inc;
        if (in_win) begin
          wsum_d = wsum_sat;
        end
        if (win_end) begin
          cnt_d   = SAMPLE_COUNT_RST;
          wsum_d  = '0;
          restart = 1'b1;
          if (sel_ok) begin
            if (!best_valid_q) begin
              best_d       = wsum_q;
              best_valid_d = 1'b1;
            end
            priority if (!inc_tried_q) begin
              gains_d[cfg_i.tune_select] = gain_inc;
              inc_tried_d                = 1'b1;
            end else if (wsum_q < best_eff) begin
              best_d                     = wsum_q;
              steps_d[cfg_i.tune_select] = step_up;
              gains_d[cfg_i.tune_select] = gain_up;
              inc_tried_d                = 1'b1;
              dec_tried_d                = 1'b0;
            end else if (!dec_tried_q) begin
              gains_d[cfg_i.tune_select] = gain_dn2;
              dec_tried_d                = 1'b1;
            end else begin
              gains_d[cfg_i.tune_select] = gain_inc;
              steps_d[cfg_i.tune_select] = step_dn;
              inc_tried_d                = 1'b0;
              dec_tried_d                = 1'b0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        gains_q[k] <= '0;
        steps_q[k] <= '0;
      end
      prev_q       <= '0;
      integ_q      <= '0;
      cnt_q        <= SAMPLE_COUNT_RST;
      wsum_q       <= '0;
      best_q       <= '0;
      best_valid_q <= 1'b0;
      inc_tried_q  <= 1'b0;
      dec_tried_q  <= 1'b0;
    end else begin
      gains_q      <= gains_d;
      steps_q      <= steps_d;
      prev_q       <= prev_d;
      integ_q      <= integ_d;
      cnt_q        <= cnt_d;
      wsum_q       <= wsum_d;
      best_q       <= best_d;
      best_valid_q <= best_valid_d;
      inc_tried_q  <= inc_tried_d;
      dec_tried_q  <= dec_tried_d;
    end
  end

  // The current sample already sees the gains of a twiddle step it triggered
  assign gains_o    = gains_d;
  assign integral_o = integ_sat;
  assign diff_o     = (SAMPLE_WIDTH+1)'(error_sample_i) - (SAMPLE_WIDTH+1)'(prev_q);
  assign restart_o  = restart;

endmodule

FILE: rtl/pidtw_datapath.sv
`timescale 1ns / 1ps
// PID drive pipeline: operand register, product register, rounded and saturated result.
// Depends on pidtw_pkg.
module pidtw_datapath #(
  parameter int unsigned GAIN_WIDTH   = 24,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0]         error_sample_i,
  input  logic signed [GAIN_WIDTH-1:0]           gains_i [3],
  input  logic signed [pidtw_pkg::ACC_WIDTH-1:0] integral_i,
  input  logic signed [SAMPLE_WIDTH:0]           diff_i,
  input  logic                                   restart_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [31:0]                     drive_o,
  output logic                                   restart_request_o
);
  import pidtw_pkg::*;

  localparam int unsigned GW  = GAIN_WIDTH;
  localparam int unsigned SW  = SAMPLE_WIDTH;
  localparam int unsigned PPW = GW + SW;
  localparam int unsigned PIW = GW + ACC_WIDTH;
  localparam int unsigned PDW = GW + SW + 1;
  localparam int unsigned TW  = PIW + 2;
  localparam int unsigned QW  = TW - 8;
  localparam logic signed [TW-1:0] RND = TW'(128);

  // Stage 1: operands
  logic                  v1_q, r1_q;
  logic signed [SW-1:0]  e1_q;
  logic signed [ACC_WIDTH-1:0] i1_q;
  logic signed [SW:0]    d1_q;
  logic signed [GW-1:0]  kp1_q, ki1_q, kd1_q;
  // Stage 2: products
  logic                  v2_q, r2_q;
  logic signed [PPW-1:0] pp_q;
  logic signed [PIW-1:0] pi_q;
  logic signed [PDW-1:0] pd_q;
  // Stage 3: result
  logic                  vo_q, ro_q;
  logic signed [31:0]    drive_q;

  logic adv_o, adv_2, adv_1;
  logic signed [TW-1:0] total;
  logic signed [QW-1:0] quot;
  logic signed [31:0]   drive_d;

  // A stage moves on when the next one is empty or moving
  assign adv_o      = !vo_q || out_ready_i;
  assign adv_2      = !v2_q || adv_o;
  assign adv_1      = !v1_q || adv_2;
  assign in_ready_o = adv_1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (adv_1) v1_q <= in_valid_i;
      if (adv_2) v2_q <= v1_q;
      if (adv_o) vo_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_1 && in_valid_i) begin
      e1_q  <= error_sample_i;
      i1_q  <= integral_i;
      d1_q  <= diff_i;
      kp1_q <= gains_i[0];
      ki1_q <= gains_i[1];
      kd1_q <= gains_i[2];
      r1_q  <= restart_i;
    end
    if (adv_2 && v1_q) begin
      pp_q <= kp1_q * e1_q;
      pi_q <= ki1_q * i1_q;
      pd_q <= kd1_q * d1_q;
      r2_q <= r1_q;
    end
    if (adv_o && v2_q) begin
      drive_q <= drive_d;
      ro_q    <= r2_q;
    end
  end

  // Arithmetic shift gives division by 256 rounded down, after the +128 bias
  assign total = TW'(pp_q) + TW'(pi_q) + TW'(pd_q) + RND;
  assign quot  = total[TW-1:8];

  always_comb begin
    if ((&quot[QW-1:31]) || !(|quot[QW-1:31])) begin
      drive_d = quot[31:0];
    end else if (quot[QW-1]) begin
      drive_d = $signed({1'b1, 31'd0});
    end else begin
      drive_d = $signed({1'b0, {31{1'b1}}});
    end
  end

  assign out_valid_o       = vo_q;
  assign drive_o           = drive_q;
  assign restart_request_o = ro_q;

endmodule

FILE: rtl/pid_controller_with_twiddle_tuning_unit.sv
`timescale 1ns / 1ps
// Top level of the PID controller with twiddle gain tuning.
// Depends on pidtw_pkg, pidtw_cfg, pidtw_tune and pidtw_datapath.
//
// Channel   Direction  Handshake               Payload
// --------  ---------  ----------------------  ---------------------------------
// sample    in         in_valid_i/in_ready_o   error_sample_i (signed Q8.8)
// result    out        out_valid_o/out_ready_i drive_o (Q16.16), restart_request_o
// config    in         APB psel/penable/pwrite paddr, pwdata, prdata, pready
//
// Throughput is one sample per clock while the result channel is not stalled; the
// accepting edge loads the state update and operands, the products register follows,
// and then the rounded and saturated result register, which drives out_valid_o.
// The integral, window and twiddle update close within the first stage, so the
// next sample follows at once. Reset is asynchronous and active low.
// A stalled output holds its result while empty stages keep filling;
// in_ready_o drops only when all three stages hold transactions.
module pid_controller_with_twiddle_tuning_unit #(
  parameter int unsigned GAIN_WIDTH   = 24,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // sample channel
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0]       error_sample_i,
  // result channel
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [31:0]                   drive_o,
  output logic                                 restart_request_o,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [pidtw_pkg::APB_ADDR_WIDTH-1:0] paddr,
  input  logic [pidtw_pkg::APB_DATA_WIDTH-1:0] pwdata,
  output logic [pidtw_pkg::APB_DATA_WIDTH-1:0] prdata,
  output logic                                 pready
);
  import pidtw_pkg::*;

  tune_cfg_t                    cfg;
  gain_load_t                   gain_load;
  logic signed [GAIN_WIDTH-1:0] load_gain, load_step;
  logic signed [GAIN_WIDTH-1:0] gains [3];
  logic signed [ACC_WIDTH-1:0]  integral;
  logic signed [SAMPLE_WIDTH:0] diff;
  logic                         restart;
  logic                         fire;

  // The controller state advances exactly once per accepted sample
  assign fire = in_valid_i & in_ready_o;

  pidtw_cfg #(
    .GAIN_WIDTH (GAIN_WIDTH)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .cfg_o       (cfg),
    .load_o      (gain_load),
    .load_gain_o (load_gain),
    .load_step_o (load_step)
  );

  pidtw_tune #(
    .GAIN_WIDTH   (GAIN_WIDTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_tune (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .error_sample_i (error_sample_i),
    .cfg_i          (cfg),
    .load_i         (gain_load),
    .load_gain_i    (load_gain),
    .load_step_i    (load_step),
    .gains_o        (gains),
    .integral_o     (integral),
    .diff_o         (diff),
    .restart_o      (restart)
  );

  pidtw_datapath #(
    .GAIN_WIDTH   (GAIN_WIDTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .error_sample_i    (error_sample_i),
    .gains_i           (gains),
    .integral_i        (integral),
    .diff_i            (diff),
    .restart_i         (restart),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .drive_o           (drive_o),
    .restart_request_o (restart_request_o)
  );

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for pid_controller_with_twiddle_tuning_unit.
// Uses pidtw_pkg for the register map and select codes; predicts drive and restart per sample.

module tb_top;
  import pidtw_pkg::*;

  localparam int         GAIN_W    = 24;
  localparam int         SAMPLE_W  = 16;
  localparam longint     GAIN_MAX  = (longint'(1) << (GAIN_W - 1)) - 1;
  localparam longint     GAIN_MIN  = -GAIN_MAX - 1;
  localparam longint     DRIVE_MAX = (longint'(1) << 31) - 1;
  localparam longint     DRIVE_MIN = -DRIVE_MAX - 1;
  // The fourth select code skips the twiddle step but still ends the window
  localparam logic [1:0] SEL_NONE  = 2'd3;
  localparam int         LATENCY   = 3;
  localparam int         RUN_LIMIT = 200000;
  localparam int         PHASES    = 8;
  localparam int         PHASE_LEN = 92;

  typedef struct {
    logic signed [31:0] drive;
    logic               restart;
  } pid_result_t;

  // DUT ports; the inputs are all driven to known values from time zero
  logic                          clk_i          = 1'b0;
  logic                          rst_ni         = 1'b0;
  logic                          in_valid_i     = 1'b0;
  logic                          in_ready_o;
  logic signed [SAMPLE_W-1:0]    error_sample_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i    = 1'b0;
  logic signed [31:0]            drive_o;
  logic                          restart_request_o;
  logic                          psel           = 1'b0;
  logic                          penable        = 1'b0;
  logic                          pwrite         = 1'b0;
  logic [APB_ADDR_WIDTH-1:0]     paddr          = '0;
  logic [APB_DATA_WIDTH-1:0]     pwdata         = '0;
  logic [APB_DATA_WIDTH-1:0]     prdata;
  logic                          pready;

  // Stimulus and scoreboard storage
  logic signed [SAMPLE_W-1:0]    error_samples_q[$];
  pid_result_t                   predicted_outputs_q[$];
  pid_result_t                   head_result;

  // Directed tuning samples: four windows of three, mixed signs and magnitudes
  logic signed [SAMPLE_W-1:0] pick_list[12] = '{
    16'sh0100, 16'shFE00, 16'sh0400, 16'sh012C, 16'shFED4, 16'sh000A,
    16'sh1388, 16'shEC78, 16'sh0002, 16'sh7FFF, 16'sh8000, 16'sh0800
  };

  // Handshake pacing shared between the posedge and negedge processes
  bit                            idle_on        = 1'b1;
  bit                            sample_taken   = 1'b0;
  int                            in_gap_left    = 0;
  int                            out_stall_left = 0;
  int                            fail_count     = 0;
  int                            cycle_count    = 0;

  // Shadow of the configuration registers
  logic                          cfg_tune_en    = 1'b0;
  logic [1:0]                    cfg_sel        = TUNE_SELECT_RST;
  logic [15:0]                   cfg_win_start  = WINDOW_START_RST;
  logic [15:0]                   cfg_win_end    = WINDOW_END_RST;

  // Controller and tuner state as the predictor tracks it
  longint                        p_prev_err     = 0;
  longint                        p_integral     = 0;
  longint                        p_gain[3]      = '{0, 0, 0};
  longint                        p_step[3]      = '{0, 0, 0};
  logic [15:0]                   p_count        = SAMPLE_COUNT_RST;
  logic [31:0]                   p_win_sum      = '0;
  logic [31:0]                   p_best_sum     = '0;
  bit                            p_best_ok      = 1'b0;
  bit                            p_up_tried     = 1'b0;
  bit                            p_down_tried   = 1'b0;

  pid_controller_with_twiddle_tuning_unit u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .error_sample_i    (error_sample_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .drive_o           (drive_o),
    .restart_request_o (restart_request_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  // One coordinate-descent move on gain k: try up, then down; widen the step on improvement, else shrink it
  function automatic void twiddle_gain(int k);
    if (!p_best_ok) begin
      p_best_sum = p_win_sum;
      p_best_ok  = 1'b1;
    end
    if (!p_up_tried) begin
      p_gain[k]  = clamp(p_gain[k] + p_step[k], GAIN_MIN, GAIN_MAX);
      p_up_tried = 1'b1;
    end else if (p_win_sum < p_best_sum) begin
      // Improvement: widen the step by 1.1 and move the gain up by the new step
      p_best_sum   = p_win_sum;
      p_step[k]    = clamp(p_step[k] * 11 / 10, GAIN_MIN, GAIN_MAX);
      p_up_tried   = 1'b1;
      p_down_tried = 1'b0;
      p_gain[k]    = clamp(p_gain[k] + p_step[k], GAIN_MIN, GAIN_MAX);
    end else if (!p_down_tried) begin
      p_gain[k]    = clamp(p_gain[k] - 2 * p_step[k], GAIN_MIN, GAIN_MAX);
      p_down_tried = 1'b1;
    end else begin
      // Neither direction helped: restore the gain and narrow the step by 0.9
      p_gain[k]    = clamp(p_gain[k] + p_step[k], GAIN_MIN, GAIN_MAX);
      p_step[k]    = clamp(p_step[k] * 9 / 10, GAIN_MIN, GAIN_MAX);
      p_down_tried = 1'b0;
      p_up_tried   = 1'b0;
    end
  endfunction

  // Advance the tuner and controller by one sample and queue the resulting output
  function automatic void predict_sample(logic signed [SAMPLE_W-1:0] sample);
    longint          e;
    longint          diff;
    longint          total;
    longint          q;
    longint unsigned s;
    pid_result_t     res;
    e           = sample;
    res.restart = 1'b0;
    if (cfg_tune_en) begin
      p_count = p_count + 16'd1;
      if (p_count > cfg_win_start && p_count < cfg_win_end) begin
        s         = longint'(p_win_sum) + ((e < 0) ? -e : e);
        p_win_sum = (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
      end
      if (p_count >= cfg_win_end) begin
        p_count = SAMPLE_COUNT_RST;
        if (cfg_sel != SEL_NONE) twiddle_gain(int'(cfg_sel));
        p_win_sum   = '0;
        res.restart = 1'b1;
      end
    end
    diff       = e - p_prev_err;
    p_prev_err = e;
    p_integral = clamp(p_integral + e, DRIVE_MIN, DRIVE_MAX);
    // Q8.16 x Q8.8 gives 24 fraction bits; round half up into Q16.16
    total      = p_gain[0] * e + p_gain[1] * p_integral + p_gain[2] * diff + 128;
    q          = clamp(total >>> 8, DRIVE_MIN, DRIVE_MAX);
    res.drive  = q[31:0];
    predicted_outputs_q.push_back(res);
  endfunction

  function automatic void apply_reg(reg_idx_e idx, logic [31:0] data);
    longint g;
    case (idx)
      REG_GAIN_P, REG_GAIN_I, REG_GAIN_D: begin
        // A gain write also reloads the active gain and resets its step to a tenth
        g                = longint'($signed(data[GAIN_W-1:0]));
        p_gain[int'(idx)] = g;
        p_step[int'(idx)] = g / 10;
      end
      REG_TUNE_ENABLE:  cfg_tune_en   = data[0];
      REG_TUNE_SELECT:  cfg_sel       = data[1:0];
      REG_WINDOW_START: cfg_win_start = data[15:0];
      REG_WINDOW_END:   cfg_win_end   = data[15:0];
      default: ;
    endcase
  endfunction

  // APB write: setup cycle, then access cycle until pready
  task automatic apb_write(reg_idx_e idx, longint value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value[31:0];
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    apply_reg(idx, value[31:0]);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Hold until every queued sample is sent and every result has come back
  task automatic wait_drained();
    while (error_samples_q.size() != 0 || in_valid_i || predicted_outputs_q.size() != 0)
      @(posedge clk_i);
  endtask

  function automatic longint pick_gain();
    case ($urandom_range(0, 5))
      0:       return GAIN_MAX;
      1:       return GAIN_MIN;
      2:       return longint'($signed(24'($urandom())));
      default: return longint'($urandom_range(0, 1 << 19)) - (1 << 18);
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:          return 16'sh7FFF;
      1:          return 16'sh8000;
      2, 3, 4:    return 16'($signed($urandom_range(0, 1023)) - 512);
      default:    return 16'($urandom());
    endcase
  endfunction

  // Sample channel: predict on every accepted transaction, then draw the next gap
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      predict_sample(error_sample_i);
      sample_taken = 1'b1;
      in_gap_left  = idle_on ? $urandom_range(0, 3) : 0;
    end
  end

  // Sample driver: hold the payload until taken, idle for the drawn gap, then advance
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!(in_valid_i && !sample_taken)) begin
      sample_taken = 1'b0;
      if (in_gap_left > 0) begin
        in_valid_i  <= 1'b0;
        in_gap_left = in_gap_left - 1;
      end else if (error_samples_q.size() != 0) begin
        in_valid_i     <= 1'b1;
        error_sample_i <= error_samples_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result side backpressure: stall for the drawn count after each transaction
  always @(negedge clk_i) begin
    if (out_stall_left > 0) begin
      out_ready_i    <= 1'b0;
      out_stall_left = out_stall_left - 1;
    end else begin
      out_ready_i <= rst_ni;
    end
  end

  // Result monitor: compare each transaction against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (predicted_outputs_q.size() == 0) begin
        fail_count = fail_count + 1;
        if (fail_count <= 10)
          $display("ERROR: unpredicted result drive=%0d restart=%0b",
                   drive_o, restart_request_o);
      end else begin
        head_result = predicted_outputs_q.pop_front();
        if (drive_o !== head_result.drive || restart_request_o !== head_result.restart) begin
          fail_count = fail_count + 1;
          if (fail_count <= 10)
            $display("ERROR: drive exp %0d got %0d, restart exp %0b got %0b",
                     head_result.drive, drive_o, head_result.restart, restart_request_o);
        end
      end
      out_stall_left = idle_on ? $urandom_range(0, 3) : 0;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic [15:0] ws;
    logic [15:0] we;
    logic [1:0]  sel;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset config: all gains zero, tuning off, drive must stay zero
    error_samples_q.push_back(16'sh7FFF);
    error_samples_q.push_back(16'sh8000);
    error_samples_q.push_back(16'sh0001);
    wait_drained();

    // Extreme gains with extreme samples: exercise drive saturation both ways
    apb_write(REG_GAIN_P, GAIN_MAX);
    apb_write(REG_GAIN_I, GAIN_MIN);
    apb_write(REG_GAIN_D, GAIN_MAX);
    error_samples_q.push_back(16'sh7FFF);
    error_samples_q.push_back(16'sh8000);
    error_samples_q.push_back(16'sh7FFF);
    error_samples_q.push_back(16'sh0000);
    error_samples_q.push_back(16'shFFFF);
    error_samples_q.push_back(16'sh0001);
    error_samples_q.push_back(16'sh8000);
    wait_drained();

    // Three-sample windows on the proportional gain: walk every twiddle branch,
    // first window included
    apb_write(REG_GAIN_P, 65536);
    apb_write(REG_GAIN_I, -6554);
    apb_write(REG_GAIN_D, 327680);
    apb_write(REG_TUNE_SELECT, SEL_P);
    apb_write(REG_WINDOW_START, 0);
    apb_write(REG_WINDOW_END, 4);
    apb_write(REG_TUNE_ENABLE, 1);
    foreach (pick_list[i]) error_samples_q.push_back(pick_list[i]);
    wait_drained();

    // Invalid select: window still ends and requests restart, gains untouched
    apb_write(REG_TUNE_SELECT, SEL_NONE);
    apb_write(REG_WINDOW_END, 2);
    error_samples_q.push_back(16'sh0100);
    error_samples_q.push_back(16'shFF00);
    wait_drained();

    // Tiny window end: every sample closes a window
    apb_write(REG_TUNE_SELECT, SEL_I);
    apb_write(REG_WINDOW_END, 0);
    error_samples_q.push_back(16'sh0040);
    wait_drained();

    // Random phases: fresh settings each time, drained before reconfiguring
    for (int ph = 0; ph < PHASES; ph++) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if (ph == 0 || $urandom_range(0, 1) == 1) begin
        apb_write(REG_GAIN_P, pick_gain());
        apb_write(REG_GAIN_I, pick_gain());
        apb_write(REG_GAIN_D, pick_gain());
      end
      if (ph == 2) begin
        // Widest window settings: no window closes within the phase
        ws = 16'hFFFF;
        we = 16'hFFFF;
      end else if (ph == 5) begin
        ws = 16'h0000;
        we = 16'd2;
      end else begin
        ws = 16'($urandom_range(0, 8));
        we = ws + 16'($urandom_range(2, 24));
      end
      sel = ($urandom_range(0, 9) == 0) ? SEL_NONE : 2'($urandom_range(SEL_P, SEL_D));
      apb_write(REG_TUNE_SELECT, sel);
      apb_write(REG_WINDOW_START, ws);
      apb_write(REG_WINDOW_END, we);
      apb_write(REG_TUNE_ENABLE, (ph == 1) ? 0 : ($urandom_range(0, 4) != 0));
      repeat (PHASE_LEN) error_samples_q.push_back(pick_sample());
      wait_drained();
    end

    // Let any stray result surface before the verdict
    repeat (LATENCY + 3) @(posedge clk_i);
    if (fail_count == 0 && predicted_outputs_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
